@@ rtl/core/mdcw_pkg.sv @@
// ----------------------------------------------------------------------------
// mdcw_pkg
// Shared types and constants of the device communication watchdog table.
// ----------------------------------------------------------------------------
package mdcw_pkg;

  localparam int SLOTS = 16;

  typedef enum logic [2:0] {
    MODE_MONITOR = 3'd0,
    MODE_STOP    = 3'd1,
    MODE_PET     = 3'd2,
    MODE_FAIL    = 3'd3,
    MODE_QUERY   = 3'd4,
    MODE_SETREM  = 3'd5,
    MODE_SWEEP   = 3'd6,
    MODE_ISMON   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ACK      = 3'd0,
    KIND_FAILED   = 3'd1,
    KIND_RESTORED = 3'd2,
    KIND_REMAIN   = 3'd3,
    KIND_MONANS   = 3'd4,
    KIND_DONE     = 3'd5
  } kind_t;

  localparam logic [0:0] CFG_FAST     = 1'd0;
  localparam logic [0:0] CFG_INTERVAL = 1'd1;
  localparam logic [15:0] CONTACT_RESET = 16'd5000;
  localparam logic [9:0]  MS_PER_S      = 10'd1000;

  // reciprocals for exact 32-bit unsigned division, used with shifts 38 and 37
  localparam logic [31:0] RECIP_1000 = 32'd274877907;
  localparam logic [31:0] RECIP_100  = 32'd1374389535;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_EMIT,
    ST_SW_NEXT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request and reset sweep index
    logic rd;         // read entry at current index
    logic calc;       // register time left
    logic div_start;  // start divider on time left
    logic exec;       // apply operation, load out register
    logic sw_step;    // advance sweep index
    logic emit_done;  // load sweep done result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sweep;
    logic need_div;
    logic div_busy;
    logic emit_fail;
    logic sw_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/mdcw_div.sv @@
// ----------------------------------------------------------------------------
// mdcw_div
// Divide a 32-bit value by 1000 or 100 by reciprocal multiplication, registered product.
// ----------------------------------------------------------------------------
module mdcw_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        by_hundred,
  input  logic [31:0] dividend,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] x_r, x_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] magic;

  assign magic = by_hundred ? mdcw_pkg::RECIP_100 : mdcw_pkg::RECIP_1000;

  always_comb begin
    x_nxt    = start ? dividend : x_r;
    busy_nxt = start;
    prod_nxt = 64'(x_r) * 64'(magic);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

  assign busy     = busy_r;
  assign quotient = by_hundred ? 32'(prod_r[63:37]) : 32'(prod_r[63:38]);

endmodule

@@ rtl/core/mdcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// mdcw_ctrl
// Sequencer of the watchdog table: one request at a time, sweeps slot by slot.
// ----------------------------------------------------------------------------
module mdcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mdcw_pkg::sts_t   sts,
  output mdcw_pkg::cmd_t   cmd
);

  mdcw_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdcw_pkg::ST_IDLE:  if (in_valid) state_nxt = mdcw_pkg::ST_READ;
      mdcw_pkg::ST_READ:  state_nxt = mdcw_pkg::ST_CALC;
      mdcw_pkg::ST_CALC:  state_nxt = sts.need_div ? mdcw_pkg::ST_DIV : mdcw_pkg::ST_EMIT;
      mdcw_pkg::ST_DIV:   if (!sts.div_busy) state_nxt = mdcw_pkg::ST_EMIT;
      mdcw_pkg::ST_EMIT: begin
        if (sts.out_free || (sts.is_sweep && !sts.emit_fail)) begin
          state_nxt = sts.is_sweep ? mdcw_pkg::ST_SW_NEXT : mdcw_pkg::ST_IDLE;
        end
      end
      mdcw_pkg::ST_SW_NEXT:
        state_nxt = sts.sw_last ? mdcw_pkg::ST_DONE : mdcw_pkg::ST_READ;
      mdcw_pkg::ST_DONE:  if (sts.out_free) state_nxt = mdcw_pkg::ST_IDLE;
      default:            state_nxt = mdcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      mdcw_pkg::ST_IDLE:  cmd.capture = in_valid;
      mdcw_pkg::ST_READ:  cmd.rd = 1'b1;
      mdcw_pkg::ST_CALC: begin
        cmd.calc      = 1'b1;
      end
      mdcw_pkg::ST_DIV:   cmd.div_start = 1'b0;
      mdcw_pkg::ST_EMIT:
        cmd.exec = sts.out_free || (sts.is_sweep && !sts.emit_fail);
      mdcw_pkg::ST_SW_NEXT: cmd.sw_step = 1'b1;
      mdcw_pkg::ST_DONE:  cmd.emit_done = sts.out_free;
      default: ;
    endcase
    cmd.div_start = (state_r == mdcw_pkg::ST_CALC) && sts.need_div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdcw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != mdcw_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
  a_div_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mdcw_pkg::ST_DIV |-> $past(state_r) == mdcw_pkg::ST_CALC ||
                                    $past(state_r) == mdcw_pkg::ST_DIV)
    else $error("divide state entered out of order");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.rd, cmd.exec, cmd.sw_step, cmd.emit_done}))
    else $error("conflicting datapath commands");
  a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mdcw_pkg::ST_DONE && $past(state_r) != mdcw_pkg::ST_DONE |->
      $past(state_r) == mdcw_pkg::ST_SW_NEXT)
    else $error("sweep done without final slot");
`endif

endmodule

@@ rtl/core/mdcw_dp.sv @@
// ----------------------------------------------------------------------------
// mdcw_dp
// Slot table, time arithmetic and output register of the watchdog table.
// ----------------------------------------------------------------------------
module mdcw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mdcw_pkg::cmd_t     cmd,
  output mdcw_pkg::sts_t     sts,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_slot,
  input  logic [47:0]        in_now_ms,
  input  logic [15:0]        in_timeout_s,
  input  logic               in_initial_fail,
  input  logic [15:0]        in_seconds_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [3:0]         out_event_slot,
  output logic signed [17:0] out_seconds_left,
  output logic               out_monitored,
  output logic               out_contact_due,
  output logic               out_last
);

  localparam int IW = $clog2(mdcw_pkg::SLOTS);

  logic [mdcw_pkg::SLOTS-1:0] valid_r, valid_nxt;
  logic [mdcw_pkg::SLOTS-1:0] failed_r, failed_nxt;
  logic [15:0] tmo_mem [mdcw_pkg::SLOTS];
  logic [31:0] rem_mem [mdcw_pkg::SLOTS];
  logic [47:0] sync_mem [mdcw_pkg::SLOTS];

  logic        fast_r;
  logic [15:0] ival_r;

  logic [2:0]  mode_r;
  logic [3:0]  slot_r;
  logic [47:0] now_r;
  logic [15:0] tin_r;
  logic        ifail_r;
  logic [15:0] sec_r;
  logic [IW:0] idx_r, idx_nxt;

  logic [15:0] e_tmo_r;
  logic [31:0] e_rem_r;
  logic [47:0] e_sync_r;
  logic        e_here_r;
  logic        e_fail_r;

  logic [47:0] elapsed_r;
  logic [31:0] left_r;
  logic [31:0] tms_r;

  logic        div_busy;
  logic [31:0] div_q;

  logic [IW-1:0] idx;
  logic          in_range;
  logic [47:0]   elapsed;
  logic [31:0]   left;
  logic          is_sweep;
  logic [31:0]   sw_ms;
  logic          sw_newfail;
  logic          load_res;

  logic        ov_r;
  logic [2:0]  okind_r, okind_nxt;
  logic [3:0]  oslot_r;
  logic [17:0] osec_r, osec_nxt;
  logic        omon_r, odue_r, olast_r;
  logic        omon_nxt, odue_nxt;

  assign is_sweep = (mode_r == mdcw_pkg::MODE_SWEEP);
  assign idx      = is_sweep ? idx_r[IW-1:0] : slot_r[IW-1:0];
  assign in_range = is_sweep ? 1'b1 : ({28'd0, slot_r} < 32'(mdcw_pkg::SLOTS));
  assign elapsed  = now_r - e_sync_r;
  assign left     = ({16'd0, e_rem_r} > elapsed) ? 32'({16'd0, e_rem_r} - elapsed) : 32'd0;
  assign sw_ms    = fast_r ? div_q : left_r;
  assign sw_newfail = e_here_r && (sw_ms == 32'd0) && !e_fail_r;
  assign load_res = cmd.exec && (!is_sweep || sw_newfail);

  mdcw_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .by_hundred (is_sweep),
    .dividend   (left),
    .busy       (div_busy),
    .quotient   (div_q)
  );

  always_comb begin
    sts.is_sweep  = is_sweep;
    sts.need_div  = (is_sweep && fast_r && e_here_r) ||
                    (mode_r == mdcw_pkg::MODE_QUERY);
    sts.div_busy  = div_busy;
    sts.emit_fail = sw_newfail;
    sts.sw_last   = (idx_r == (IW+1)'(mdcw_pkg::SLOTS - 1)) ||
                    (idx_r >= (IW+1)'(mdcw_pkg::SLOTS - 1));
    sts.out_free  = !ov_r || !out_stall;
  end

  // slot table, read the entry at the current index on a read command
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      e_tmo_r  <= tmo_mem[idx];
      e_rem_r  <= rem_mem[idx];
      e_sync_r <= sync_mem[idx];
      e_here_r <= in_range && valid_r[idx];
      e_fail_r <= failed_r[idx];
    end
    if (cmd.calc) begin
      elapsed_r <= elapsed;
      left_r    <= left;
      tms_r     <= 32'(e_tmo_r) * 32'(mdcw_pkg::MS_PER_S);
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    failed_nxt = failed_r;
    if (cmd.exec && e_here_r) begin
      unique case (mode_r)
        mdcw_pkg::MODE_STOP: begin
          valid_nxt[idx]  = 1'b0;
          failed_nxt[idx] = 1'b0;
        end
        mdcw_pkg::MODE_PET:   failed_nxt[idx] = 1'b0;
        mdcw_pkg::MODE_FAIL:  failed_nxt[idx] = 1'b1;
        mdcw_pkg::MODE_SWEEP: if (sw_newfail) failed_nxt[idx] = 1'b1;
        default: ;
      endcase
    end
    if (cmd.exec && mode_r == mdcw_pkg::MODE_MONITOR && in_range && !e_here_r &&
        tin_r != 16'd0) begin
      valid_nxt[idx]  = 1'b1;
      failed_nxt[idx] = ifail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      priority if (mode_r == mdcw_pkg::MODE_MONITOR && in_range && !e_here_r &&
                   tin_r != 16'd0) begin
        tmo_mem[idx]  <= tin_r;
        rem_mem[idx]  <= 32'(tin_r) * 32'(mdcw_pkg::MS_PER_S);
        sync_mem[idx] <= now_r;
      end else if (e_here_r && mode_r == mdcw_pkg::MODE_PET) begin
        rem_mem[idx]  <= tms_r;
        sync_mem[idx] <= now_r;
      end else if (e_here_r && !e_fail_r && mode_r == mdcw_pkg::MODE_SETREM) begin
        rem_mem[idx]  <= 32'(sec_r) * 32'(mdcw_pkg::MS_PER_S);
        sync_mem[idx] <= now_r;
      end else if (e_here_r && is_sweep) begin
        rem_mem[idx]  <= sw_ms;
        sync_mem[idx] <= now_r;
      end else begin
      end
    end
  end

  // result fields of the current request
  always_comb begin
    okind_nxt = mdcw_pkg::KIND_ACK;
    osec_nxt  = '0;
    omon_nxt  = 1'b0;
    odue_nxt  = 1'b0;
    unique case (mode_r)
      mdcw_pkg::MODE_SWEEP: okind_nxt = mdcw_pkg::KIND_FAILED;
      mdcw_pkg::MODE_PET: begin
        if (e_here_r) begin
          odue_nxt = (elapsed_r >= {32'd0, ival_r});
          if (e_fail_r) okind_nxt = mdcw_pkg::KIND_RESTORED;
        end
      end
      mdcw_pkg::MODE_FAIL:
        if (e_here_r && !e_fail_r) okind_nxt = mdcw_pkg::KIND_FAILED;
      mdcw_pkg::MODE_QUERY: begin
        okind_nxt = mdcw_pkg::KIND_REMAIN;
        if (e_here_r && !e_fail_r) begin
          osec_nxt = 18'(div_q) +
                     ((sec_r >= e_tmo_r) ? 18'(sec_r - e_tmo_r) : 18'd0);
        end else begin
          osec_nxt = '1;
        end
      end
      mdcw_pkg::MODE_ISMON: begin
        okind_nxt = mdcw_pkg::KIND_MONANS;
        omon_nxt  = e_here_r;
      end
      default: ;
    endcase
  end

  // output register and request capture
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture) idx_nxt = '0;
    else if (cmd.sw_step) idx_nxt = idx_r + (IW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      failed_r <= '0;
      fast_r  <= 1'b0;
      ival_r  <= mdcw_pkg::CONTACT_RESET;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r  <= valid_nxt;
      failed_r <= failed_nxt;
      idx_r    <= idx_nxt;
      if (cfg_we) begin
        if (cfg_index == mdcw_pkg::CFG_FAST) fast_r <= cfg_wdata[0];
        else ival_r <= cfg_wdata;
      end
      if (cmd.emit_done || load_res) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      slot_r  <= in_slot;
      now_r   <= in_now_ms;
      tin_r   <= in_timeout_s;
      ifail_r <= in_initial_fail;
      sec_r   <= in_seconds_value;
    end
    if (cmd.emit_done) begin
      okind_r <= mdcw_pkg::KIND_DONE;
      oslot_r <= '0;
      osec_r  <= '0;
      omon_r  <= 1'b0;
      odue_r  <= 1'b0;
      olast_r <= 1'b1;
    end else if (load_res) begin
      okind_r <= okind_nxt;
      oslot_r <= is_sweep ? 4'(idx_r) : slot_r;
      osec_r  <= osec_nxt;
      omon_r  <= omon_nxt;
      odue_r  <= odue_nxt;
      olast_r <= !is_sweep;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_event_slot   = oslot_r;
  assign out_seconds_left = osec_r;
  assign out_monitored    = omon_r;
  assign out_contact_due  = odue_r;
  assign out_last         = olast_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(okind_r) && $stable(oslot_r))
    else $error("pending result overwritten");
  a_no_fail_unmon: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (failed_r & ~valid_r) == '0)
    else $error("failed mark on unmonitored slot");
  a_sweep_idx: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= (IW+1)'(mdcw_pkg::SLOTS))
    else $error("sweep index out of range");
`endif

endmodule

@@ rtl/core/multi_device_comm_watchdog.sv @@
// Sequence: a request passes the read, calc and emit states before its result is
// registered, a query also the divide state (reciprocal divide by 1000); a stalled
// result holds the block. One request at a time; a sweep runs read, calc, emit and
// step per slot (and a divide by 100 per monitored slot in fast mode), then done.
// Reset (rst_n, synchronous): all slots unmonitored, fast mode off, contact
// interval 5000 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_device_comm_watchdog
// Per-device communication watchdog table with slot-by-slot check sweep.
// ----------------------------------------------------------------------------
module multi_device_comm_watchdog (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_slot,
  input  logic [47:0]        in_now_ms,
  input  logic [15:0]        in_timeout_s,
  input  logic               in_initial_fail,
  input  logic [15:0]        in_seconds_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [3:0]         out_event_slot,
  output logic signed [17:0] out_seconds_left,
  output logic               out_monitored,
  output logic               out_contact_due,
  output logic               out_last
);

  mdcw_pkg::cmd_t cmd;
  mdcw_pkg::sts_t sts;

  mdcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdcw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_now_ms        (in_now_ms),
    .in_timeout_s     (in_timeout_s),
    .in_initial_fail  (in_initial_fail),
    .in_seconds_value (in_seconds_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_event_slot   (out_event_slot),
    .out_seconds_left (out_seconds_left),
    .out_monitored    (out_monitored),
    .out_contact_due  (out_contact_due),
    .out_last         (out_last)
  );

endmodule

@@ bench/multi_device_comm_watchdog_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_device_comm_watchdog_tb
// Drives watchdog table requests through a directed table and then random
// phases under several register settings, predicts results with an in-bench
// model of the slot table or from the directed table, and checks each result
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module multi_device_comm_watchdog_tb;

  localparam int NSLOT = mdcw_pkg::SLOTS;

  typedef struct {
    mdcw_pkg::kind_t    kind;
    logic [3:0]         slot;
    logic signed [17:0] secs;
    logic               mon;
    logic               due;
    logic               last;
  } res_t;

  typedef struct {
    mdcw_pkg::mode_t    mode;
    logic [3:0]         slot;
    logic [47:0]        now;
    logic [15:0]        tmo;
    logic               ifail;
    logic [15:0]        secv;
    bit                 typed;
    mdcw_pkg::kind_t    kind;
    logic signed [17:0] secs;
    logic               mon;
    logic               due;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_mode;
  logic [3:0]         in_slot;
  logic [47:0]        in_now_ms;
  logic [15:0]        in_timeout_s;
  logic               in_initial_fail;
  logic [15:0]        in_seconds_value;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_kind;
  logic [3:0]         out_event_slot;
  logic signed [17:0] out_seconds_left;
  logic               out_monitored;
  logic               out_contact_due;
  logic               out_last;

  multi_device_comm_watchdog u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_slot(in_slot), .in_now_ms(in_now_ms), .in_timeout_s(in_timeout_s),
    .in_initial_fail(in_initial_fail), .in_seconds_value(in_seconds_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_event_slot(out_event_slot), .out_seconds_left(out_seconds_left),
    .out_monitored(out_monitored), .out_contact_due(out_contact_due),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog table copy
  logic        wd_valid [NSLOT];
  logic        wd_failed [NSLOT];
  logic [15:0] wd_tmo [NSLOT];
  logic [31:0] wd_rem [NSLOT];
  logic [47:0] wd_sync [NSLOT];
  logic        wd_fast;
  logic [15:0] wd_interval;

  res_t        pending_results[$];
  res_t        step_results[$];
  int          errors = 0;
  int          burst_left = 0;
  int          stall_pct = 0;
  int          stall_cnt = 0;
  row_t        plan[24];
  logic [47:0] clock_ms;

  function automatic res_t mk_res(mdcw_pkg::kind_t k, logic [3:0] s,
                                  logic signed [17:0] secs,
                                  logic mon, logic due, logic last);
    res_t r;
    r.kind = k; r.slot = s; r.secs = secs; r.mon = mon; r.due = due; r.last = last;
    return r;
  endfunction

  function automatic row_t mk_row(mdcw_pkg::mode_t m, logic [3:0] s, logic [47:0] now,
                                  logic [15:0] tmo, logic ifail, logic [15:0] secv,
                                  bit typed, mdcw_pkg::kind_t k,
                                  logic signed [17:0] secs, logic mon, logic due);
    row_t r;
    r.mode = m; r.slot = s; r.now = now; r.tmo = tmo; r.ifail = ifail; r.secv = secv;
    r.typed = typed; r.kind = k; r.secs = secs; r.mon = mon; r.due = due;
    return r;
  endfunction

  function automatic logic [31:0] ms_left(int s, logic [47:0] now);
    logic [47:0] el;
    el = now - wd_sync[s];
    return ({16'd0, wd_rem[s]} > el) ? wd_rem[s] - el[31:0] : 32'd0;
  endfunction

  function automatic void watchdog_step(mdcw_pkg::mode_t m, logic [3:0] s,
                                        logic [47:0] now, logic [15:0] tmo,
                                        logic ifail, logic [15:0] secv);
    logic               here;
    logic [47:0]        el;
    logic [31:0]        ms;
    logic signed [17:0] secs;
    mdcw_pkg::kind_t    k;
    here = wd_valid[s];
    step_results.delete();
    case (m)
      mdcw_pkg::MODE_MONITOR: begin
        if (tmo != 16'd0 && !here) begin
          wd_valid[s] = 1'b1;
          wd_failed[s] = ifail;
          wd_tmo[s] = tmo;
          wd_sync[s] = now;
          wd_rem[s] = tmo * 32'd1000;
        end
        step_results.push_back(mk_res(mdcw_pkg::KIND_ACK, s, 18'sd0, 1'b0, 1'b0, 1'b1));
      end
      mdcw_pkg::MODE_STOP: begin
        if (here) begin
          wd_valid[s] = 1'b0;
          wd_failed[s] = 1'b0;
        end
        step_results.push_back(mk_res(mdcw_pkg::KIND_ACK, s, 18'sd0, 1'b0, 1'b0, 1'b1));
      end
      mdcw_pkg::MODE_PET: begin
        k = mdcw_pkg::KIND_ACK;
        el = '0;
        if (here) begin
          el = now - wd_sync[s];
          wd_sync[s] = now;
          wd_rem[s] = wd_tmo[s] * 32'd1000;
          if (wd_failed[s]) begin
            wd_failed[s] = 1'b0;
            k = mdcw_pkg::KIND_RESTORED;
          end
        end
        step_results.push_back(mk_res(k, s, 18'sd0, 1'b0, here && el >= wd_interval,
                                      1'b1));
      end
      mdcw_pkg::MODE_FAIL: begin
        k = mdcw_pkg::KIND_ACK;
        if (here && !wd_failed[s]) begin
          wd_failed[s] = 1'b1;
          k = mdcw_pkg::KIND_FAILED;
        end
        step_results.push_back(mk_res(k, s, 18'sd0, 1'b0, 1'b0, 1'b1));
      end
      mdcw_pkg::MODE_QUERY: begin
        secs = -18'sd1;
        if (here && !wd_failed[s]) begin
          secs = 18'(ms_left(s, now) / 32'd1000);
          if (secv >= wd_tmo[s]) secs = secs + 18'(secv - wd_tmo[s]);
        end
        step_results.push_back(mk_res(mdcw_pkg::KIND_REMAIN, s, secs, 1'b0, 1'b0, 1'b1));
      end
      mdcw_pkg::MODE_SETREM: begin
        if (here && !wd_failed[s]) begin
          wd_sync[s] = now;
          wd_rem[s] = secv * 32'd1000;
        end
        step_results.push_back(mk_res(mdcw_pkg::KIND_ACK, s, 18'sd0, 1'b0, 1'b0, 1'b1));
      end
      mdcw_pkg::MODE_SWEEP: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (wd_valid[i]) begin
            ms = ms_left(i, now);
            if (wd_fast) ms = ms / 32'd100;
            if (ms == 32'd0 && !wd_failed[i]) begin
              wd_failed[i] = 1'b1;
              step_results.push_back(mk_res(mdcw_pkg::KIND_FAILED, 4'(i), 18'sd0,
                                            1'b0, 1'b0, 1'b0));
            end
            wd_sync[i] = now;
            wd_rem[i] = ms;
          end
        end
        step_results.push_back(mk_res(mdcw_pkg::KIND_DONE, 4'd0, 18'sd0, 1'b0, 1'b0,
                                      1'b1));
      end
      default: step_results.push_back(mk_res(mdcw_pkg::KIND_MONANS, s, 18'sd0, here,
                                             1'b0, 1'b1));
    endcase
  endfunction

  task automatic send_req(mdcw_pkg::mode_t m, logic [3:0] s, logic [47:0] now,
                          logic [15:0] tmo, logic ifail, logic [15:0] secv);
    // bursts of requests with random gaps, sometimes long stretches back to back
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_slot <= s;
    in_now_ms <= now;
    in_timeout_s <= tmo;
    in_initial_fail <= ifail;
    in_seconds_value <= secv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    watchdog_step(m, s, now, tmo, ifail, secv);
  endtask

  task automatic write_cfg(logic fast, logic [15:0] interval);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mdcw_pkg::CFG_FAST;
    cfg_wdata <= {15'd0, fast};
    @(posedge clk);
    cfg_index <= mdcw_pkg::CFG_INTERVAL;
    cfg_wdata <= interval;
    @(posedge clk);
    cfg_we <= 1'b0;
    wd_fast = fast;
    wd_interval = interval;
  endtask

  task automatic random_phase(int count);
    mdcw_pkg::mode_t m;
    int              pick;
    logic [15:0]     tmo;
    logic [15:0]     secv;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      m = mdcw_pkg::MODE_MONITOR;
      else if (pick < 28) m = mdcw_pkg::MODE_STOP;
      else if (pick < 43) m = mdcw_pkg::MODE_PET;
      else if (pick < 51) m = mdcw_pkg::MODE_FAIL;
      else if (pick < 63) m = mdcw_pkg::MODE_QUERY;
      else if (pick < 73) m = mdcw_pkg::MODE_SETREM;
      else if (pick < 88) m = mdcw_pkg::MODE_SWEEP;
      else                m = mdcw_pkg::MODE_ISMON;
      if ($urandom_range(0, 19) == 0) clock_ms = 48'({$urandom, $urandom});
      else clock_ms = clock_ms + 48'($urandom_range(0, 4000));
      case ($urandom_range(0, 9))
        0:       tmo = 16'd0;
        1:       tmo = 16'hffff;
        2:       tmo = 16'($urandom);
        default: tmo = 16'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 5))
        0:       secv = 16'hffff;
        1:       secv = 16'($urandom);
        default: secv = 16'($urandom_range(0, 30));
      endcase
      send_req(m, 4'($urandom), clock_ms, tmo, 1'($urandom), secv);
      foreach (step_results[j]) pending_results.push_back(step_results[j]);
    end
  endtask

  // result side: check against oldest expectation, stall on a pattern of its own
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result kind %0d slot %0d", $time, out_kind,
                 out_event_slot);
        errors++;
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (out_kind !== e.kind) begin
          $display("%0t kind exp %0d got %0d", $time, e.kind, out_kind); errors++;
        end
        if (out_event_slot !== e.slot) begin
          $display("%0t slot exp %0d got %0d", $time, e.slot, out_event_slot); errors++;
        end
        if (out_seconds_left !== e.secs) begin
          $display("%0t seconds_left exp %0d got %0d", $time, e.secs,
                   out_seconds_left);
          errors++;
        end
        if (out_monitored !== e.mon) begin
          $display("%0t monitored exp %0d got %0d", $time, e.mon, out_monitored);
          errors++;
        end
        if (out_contact_due !== e.due) begin
          $display("%0t contact_due exp %0d got %0d", $time, e.due, out_contact_due);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t last exp %0d got %0d", $time, e.last, out_last); errors++;
        end
      end
    end
    if (stall_cnt == 0) begin
      stall_cnt = $urandom_range(50, 300);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
    end
    stall_cnt--;
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    plan[0]  = mk_row(mdcw_pkg::MODE_ISMON, 0, 0, 0, 0, 0, 1, mdcw_pkg::KIND_MONANS,
                      0, 0, 0);
    plan[1]  = mk_row(mdcw_pkg::MODE_QUERY, 3, 0, 0, 0, 5, 1, mdcw_pkg::KIND_REMAIN,
                      -1, 0, 0);
    plan[2]  = mk_row(mdcw_pkg::MODE_PET, 3, 9000, 0, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[3]  = mk_row(mdcw_pkg::MODE_FAIL, 3, 0, 0, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[4]  = mk_row(mdcw_pkg::MODE_SETREM, 3, 0, 0, 0, 7, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[5]  = mk_row(mdcw_pkg::MODE_MONITOR, 0, 0, 0, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[6]  = mk_row(mdcw_pkg::MODE_MONITOR, 0, 0, 10, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[7]  = mk_row(mdcw_pkg::MODE_MONITOR, 0, 100, 20, 1, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[8]  = mk_row(mdcw_pkg::MODE_ISMON, 0, 0, 0, 0, 0, 1, mdcw_pkg::KIND_MONANS,
                      0, 1, 0);
    plan[9]  = mk_row(mdcw_pkg::MODE_QUERY, 0, 2500, 0, 0, 0, 0, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[10] = mk_row(mdcw_pkg::MODE_QUERY, 0, 2500, 0, 0, 15, 0, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[11] = mk_row(mdcw_pkg::MODE_PET, 0, 9000, 0, 0, 0, 0, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[12] = mk_row(mdcw_pkg::MODE_MONITOR, 15, 48'hffff_ffff_ffff, 16'hffff, 1, 0,
                      1, mdcw_pkg::KIND_ACK, 0, 0, 0);
    plan[13] = mk_row(mdcw_pkg::MODE_QUERY, 15, 0, 0, 0, 16'hffff, 1,
                      mdcw_pkg::KIND_REMAIN, -1, 0, 0);
    plan[14] = mk_row(mdcw_pkg::MODE_PET, 15, 5, 0, 0, 0, 0, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[15] = mk_row(mdcw_pkg::MODE_FAIL, 15, 6, 0, 0, 0, 1, mdcw_pkg::KIND_FAILED,
                      0, 0, 0);
    plan[16] = mk_row(mdcw_pkg::MODE_FAIL, 15, 7, 0, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[17] = mk_row(mdcw_pkg::MODE_SETREM, 15, 8, 0, 0, 9, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[18] = mk_row(mdcw_pkg::MODE_SETREM, 0, 9000, 0, 0, 16'hffff, 1,
                      mdcw_pkg::KIND_ACK, 0, 0, 0);
    plan[19] = mk_row(mdcw_pkg::MODE_QUERY, 0, 9000, 0, 0, 16'hffff, 0,
                      mdcw_pkg::KIND_ACK, 0, 0, 0);
    plan[20] = mk_row(mdcw_pkg::MODE_MONITOR, 5, 0, 1, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[21] = mk_row(mdcw_pkg::MODE_SWEEP, 9, 100000, 0, 0, 0, 0, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[22] = mk_row(mdcw_pkg::MODE_STOP, 15, 100000, 0, 0, 0, 1, mdcw_pkg::KIND_ACK,
                      0, 0, 0);
    plan[23] = mk_row(mdcw_pkg::MODE_ISMON, 15, 100000, 0, 0, 0, 1,
                      mdcw_pkg::KIND_MONANS, 0, 0, 0);

    for (int i = 0; i < NSLOT; i++) begin
      wd_valid[i] = 1'b0;
      wd_failed[i] = 1'b0;
      wd_tmo[i] = '0;
      wd_rem[i] = '0;
      wd_sync[i] = '0;
    end
    wd_fast = 1'b0;
    wd_interval = mdcw_pkg::CONTACT_RESET;
    clock_ms = 48'd100000;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= mdcw_pkg::CFG_FAST;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_mode <= mdcw_pkg::MODE_MONITOR;
    in_slot <= '0;
    in_now_ms <= '0;
    in_timeout_s <= '0;
    in_initial_fail <= 1'b0;
    in_seconds_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_req(plan[i].mode, plan[i].slot, plan[i].now, plan[i].tmo, plan[i].ifail,
               plan[i].secv);
      if (plan[i].typed)
        pending_results.push_back(mk_res(plan[i].kind, plan[i].slot, plan[i].secs,
                                         plan[i].mon, plan[i].due, 1'b1));
      else
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
    end
    in_valid <= 1'b0;

    write_cfg(1'b1, 16'd0);
    random_phase(40);
    in_valid <= 1'b0;
    write_cfg(1'b0, 16'hffff);
    random_phase(40);
    in_valid <= 1'b0;
    write_cfg(1'b1, 16'($urandom_range(0, 9000)));
    random_phase(40);
    in_valid <= 1'b0;
    write_cfg(1'b0, 16'd5000);
    random_phase(40);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("multi_device_comm_watchdog test passed");
    else $display("multi_device_comm_watchdog test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("multi_device_comm_watchdog test failed");
    $finish;
  end

endmodule
